[hw/rtl/sorted_priority_queue_assert.svh]
// Assertion macros for the sorted priority queue.
// Used by the top level only; needs clock and reset in scope.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/spq_pkg.sv]
// Package for the sorted priority queue: item types, cell link types and codes.
// No dependencies; used by spq_cell and sorted_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_W         = 32;
   localparam int PAYLOAD_W     = 32;
   localparam int FILL_W        = 5;
   localparam int STATUS_W      = 2;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // register index of largest_first
   localparam logic CSR_IDX_LARGEST_FIRST = 1'b0;

   typedef struct packed {
      logic                 action;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } spq_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [KEY_W-1:0]     out_key;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [FILL_W-1:0]    fill;
   } spq_rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic                 insert;
      logic                 remove;
      logic                 largest_first;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } spq_cmd_type;

   // what a cell shows its neighbours; ahead is set when the new key goes in
   // front of this cell and of every stored entry behind it, and on empty cells
   typedef struct packed {
      logic                 valid;
      logic                 ahead;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } spq_link_type;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire spq_pkg::spq_cmd_type  cmd,
   input  wire spq_pkg::spq_link_type prev_link,
   input  wire spq_pkg::spq_link_type next_link,
   output spq_pkg::spq_link_type      own_link
);

   logic                          valid_ff, valid_in;
   logic [spq_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [spq_pkg::PAYLOAD_W-1:0] payload_ff, payload_in;
   logic                          precede;
   logic                          ahead;

   always_comb begin
      if (cmd.largest_first) begin
         precede = cmd.key > key_ff;
      end else begin
         precede = cmd.key < key_ff;
      end
      ahead = !valid_ff || (precede && next_link.ahead);
   end

   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      payload_in = payload_ff;
      if (cmd.insert) begin
         if (prev_link.valid && prev_link.ahead) begin
            valid_in   = 1'b1;
            key_in     = prev_link.key;
            payload_in = prev_link.payload;
         end else if (ahead && (valid_ff || prev_link.valid)) begin
            valid_in   = 1'b1;
            key_in     = cmd.key;
            payload_in = cmd.payload;
         end
      end else if (cmd.remove) begin
         valid_in   = next_link.valid;
         key_in     = next_link.key;
         payload_in = next_link.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign own_link = '{valid: valid_ff, ahead: ahead, key: key_ff, payload: payload_ff};

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// Sorted priority queue: a row of DEPTH compare-and-shift cells with the head in cell 0.
// An insert or a remove that is served updates every cell in the cycle it is accepted, so
// one item is taken per clock cycle unless a stalled result holds the input channel; its
// result is registered in the output register at the same edge. The rate is set by the
// broadcast compare across the row of cells. No clearing pass runs after reset.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire spq_pkg::spq_req_type                req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output spq_pkg::spq_rsp_type                     rsp_data,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [spq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [spq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [spq_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   logic                   largest_first_ff, largest_first_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   spq_pkg::spq_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   req_accept;
   logic                   full, empty;
   logic                   csr_hit;
   logic [CntW+4:0]        count_ext;
   spq_pkg::spq_cmd_type   cmd;
   spq_pkg::spq_link_type  cell_link [DEPTH];
   logic [DEPTH-1:0]       valid_vec;
   logic                   rsp_ok;
   logic                   full_drop;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == spq_pkg::CSR_IDX_LARGEST_FIRST) &&
                       (csr_paddr[1:0] == 2'b00);

   always_comb begin
      largest_first_in = largest_first_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         largest_first_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata[0] = largest_first_ff;
      end
   end

   // handshake and commands to the cells
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign full       = (count_ff == FullCnt);
   assign empty      = (count_ff == '0);

   always_comb begin
      cmd.insert        = req_accept && (req_data.action == spq_pkg::ACTION_INSERT) && !full;
      cmd.remove        = req_accept && (req_data.action == spq_pkg::ACTION_REMOVE) && !empty;
      cmd.largest_first = largest_first_ff;
      cmd.key           = req_data.key;
      cmd.payload       = req_data.payload;
   end

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         spq_pkg::spq_link_type prev_l, next_l;
         if (i == 0) begin : g_head
            assign prev_l = '{valid: 1'b1, ahead: 1'b0, key: '0, payload: '0};
         end else begin : g_mid
            assign prev_l = cell_link[i-1];
         end
         if (i == DEPTH - 1) begin : g_tail
            assign next_l = '{valid: 1'b0, ahead: 1'b1, key: '0, payload: '0};
         end else begin : g_body
            assign next_l = cell_link[i+1];
         end
         spq_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .prev_link (prev_l),
            .next_link (next_l),
            .own_link  (cell_link[i])
         );
         assign valid_vec[i] = cell_link[i].valid;
      end
   endgenerate

   // count and result register
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CntW'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CntW'(1);
      end
      count_ext = {5'b0, count_in};

      rsp_data_in             = rsp_data_ff;
      rsp_data_in.status      = spq_pkg::STATUS_OK;
      rsp_data_in.out_key     = '0;
      rsp_data_in.out_payload = '0;
      rsp_data_in.fill        = count_ext[4:0];
      if (req_data.action == spq_pkg::ACTION_INSERT) begin
         if (full) begin
            rsp_data_in.status = spq_pkg::STATUS_FULL;
         end
      end else if (empty) begin
         rsp_data_in.status = spq_pkg::STATUS_EMPTY;
      end else begin
         rsp_data_in.out_key     = cell_link[0].key;
         rsp_data_in.out_payload = cell_link[0].payload;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         largest_first_ff <= 1'b1;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         largest_first_ff <= largest_first_in;
         count_ff         <= count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rsp_ok    = rsp_valid && (rsp_data.status == spq_pkg::STATUS_OK);
   assign full_drop = req_accept && (req_data.action == spq_pkg::ACTION_INSERT) && full;

   `SPQ_ASSERT(a_count_range, count_ff <= FullCnt, "entry count above depth")
   `SPQ_ASSERT(a_count_cells, $countones(valid_vec) == int'(count_ff), "count differs from cells")
   `SPQ_ASSERT_NEXT(a_remove_ok, cmd.remove, rsp_ok, "remove not served")
   `SPQ_ASSERT_NEXT(a_drop_full, full_drop, $stable(count_ff), "full insert changed count")

endmodule

`default_nettype wire
